@@ hw/rtl/shadow_tile_shelf_allocator_defines.svh @@
// Assertion macros shared by the allocator checker.
// Depends on nothing; included by the checker file.
`ifndef SHADOW_TILE_SHELF_ALLOCATOR_DEFINES_SVH
`define SHADOW_TILE_SHELF_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/stsa_pkg.sv @@
// Package of the shadow tile shelf allocator: widths, codes and shared types.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps
package stsa_pkg;

  localparam int unsigned SLOT_COUNT = 16;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned DIST_W     = 24;
  localparam int unsigned SIDE_W     = 13;
  localparam int unsigned POS_W      = 13;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned LIGHT_W    = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [POS_W:0] ATLAS_SIDE = 14'd4096;

  localparam logic [DIST_W-1:0] NEAR_RST = 24'd5120;
  localparam logic [DIST_W-1:0] MID_RST  = 24'd12800;
  localparam logic [DIST_W-1:0] FAR_RST  = 24'd25600;
  localparam logic [SIDE_W-1:0] HIGH_RST = 13'd1024;
  localparam logic [SIDE_W-1:0] MED_RST  = 13'd512;
  localparam logic [SIDE_W-1:0] LOW_RST  = 13'd256;

  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_NO_SHADOW = 3'd1,
    ST_FULL      = 3'd2,
    ST_NO_SLOT   = 3'd3,
    ST_FREED     = 3'd4,
    ST_IGNORED   = 3'd5
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEAR   = 3'd0,
    CFG_MID    = 3'd1,
    CFG_FAR    = 3'd2,
    CFG_HIGH   = 3'd3,
    CFG_MEDIUM = 3'd4,
    CFG_LOW    = 3'd5
  } cfg_idx_e;

  typedef enum logic [0:0] {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_e;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

endpackage

@@ hw/rtl/stsa_datapath.sv @@
// Datapath of the allocator: configuration, slot flags, shelf state and result register.
// Depends on stsa_pkg; driven by stsa_controller through ctrl_cmd_t.
`timescale 1ns / 1ps
module stsa_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [stsa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [stsa_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  stsa_pkg::ctrl_cmd_t                 cmd_i,
  input  logic                                req_func_i,
  input  logic [stsa_pkg::IN_DATA_W-1:0]      req_data_i,
  output logic [2:0]                          rsp_status_o,
  output logic [stsa_pkg::OUT_DATA_W-1:0]     rsp_data_o
);
  import stsa_pkg::*;

  logic [DIST_W-1:0] near_q, mid_q, far_q;
  logic [SIDE_W-1:0] high_q, med_q, low_q;

  logic              func_q;
  logic [DIST_W-1:0] dist_q;
  logic [SLOT_W-1:0] slot_q;

  logic [SLOT_COUNT-1:0] active_q, active_d;
  logic [POS_W-1:0]      shelf_x_q, shelf_x_d;
  logic [POS_W-1:0]      shelf_y_q, shelf_y_d;
  logic [SIDE_W-1:0]     shelf_h_q, shelf_h_d;
  logic [CNT_W-1:0]      used_q, used_d;

  logic [2:0]         status_q, status_d;
  logic [SLOT_W-1:0]  sout_q, sout_d;
  logic [COORD_W-1:0] ox_q, ox_d, oy_q, oy_d;
  logic [SIDE_W-1:0]  osize_q, osize_d;

  logic [SIDE_W-1:0] side;
  logic              has_side;
  logic [SLOT_W-1:0] free_idx;
  logic              found;
  logic              advance;
  logic              fits;
  logic [POS_W-1:0]  x_a, y_a;
  logic [SIDE_W-1:0] h_a;
  logic [POS_W:0]    x_sum, y_sum, y_adv;
  logic              slot_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q <= NEAR_RST;
      mid_q  <= MID_RST;
      far_q  <= FAR_RST;
      high_q <= HIGH_RST;
      med_q  <= MED_RST;
      low_q  <= LOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_NEAR:   near_q <= cfg_data_i;
        CFG_MID:    mid_q  <= cfg_data_i;
        CFG_FAR:    far_q  <= cfg_data_i;
        CFG_HIGH:   high_q <= cfg_data_i[SIDE_W-1:0];
        CFG_MEDIUM: med_q  <= cfg_data_i[SIDE_W-1:0];
        CFG_LOW:    low_q  <= cfg_data_i[SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= req_func_i;
      slot_q <= req_data_i[LIGHT_W+DIST_W+SLOT_W-1:LIGHT_W+DIST_W];
      dist_q <= req_data_i[LIGHT_W+DIST_W-1:LIGHT_W];
    end
  end

  always_comb begin
    has_side = 1'b1;
    if (dist_q <= near_q) begin
      side = high_q;
    end else if (dist_q <= mid_q) begin
      side = med_q;
    end else if (dist_q <= far_q) begin
      side = low_q;
    end else begin
      side     = '0;
      has_side = 1'b0;
    end
  end

  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        found    = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    x_sum   = {1'b0, shelf_x_q} + {1'b0, side};
    advance = x_sum > ATLAS_SIDE;
    y_adv   = {1'b0, shelf_y_q} + {1'b0, shelf_h_q};
    x_a     = advance ? '0 : shelf_x_q;
    y_a     = advance ? y_adv[POS_W-1:0] : shelf_y_q;
    h_a     = advance ? '0 : shelf_h_q;
    y_sum   = {1'b0, y_a} + {1'b0, side};
    fits    = y_sum <= ATLAS_SIDE;
  end

  assign slot_valid = ({1'b0, slot_q} < (SLOT_W + 1)'(SLOT_COUNT));

  always_comb begin
    active_d  = active_q;
    shelf_x_d = shelf_x_q;
    shelf_y_d = shelf_y_q;
    shelf_h_d = shelf_h_q;
    used_d    = used_q;
    status_d  = ST_NO_SHADOW;
    sout_d    = '0;
    ox_d      = '0;
    oy_d      = '0;
    osize_d   = '0;
    if (func_q == FUNC_ALLOC) begin
      if (!has_side) begin
        status_d = ST_NO_SHADOW;
      end else if (!found) begin
        status_d = ST_NO_SLOT;
      end else begin
        shelf_x_d = x_a;
        shelf_y_d = y_a;
        shelf_h_d = h_a;
        if (!fits) begin
          status_d = ST_FULL;
        end else begin
          shelf_x_d          = x_a + side;
          shelf_h_d          = (side > h_a) ? side : h_a;
          active_d[free_idx] = 1'b1;
          used_d             = used_q + 1'b1;
          status_d           = ST_ALLOCATED;
          sout_d             = free_idx;
          ox_d               = x_a[COORD_W-1:0];
          oy_d               = y_a[COORD_W-1:0];
          osize_d            = side;
        end
      end
    end else begin
      sout_d = slot_q;
      if (slot_valid && active_q[slot_q]) begin
        active_d[slot_q] = 1'b0;
        used_d           = used_q - 1'b1;
        status_d         = ST_FREED;
      end else begin
        status_d = ST_IGNORED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= '0;
      shelf_x_q <= '0;
      shelf_y_q <= '0;
      shelf_h_q <= '0;
      used_q    <= '0;
    end else if (cmd_i.execute) begin
      active_q  <= active_d;
      shelf_x_q <= shelf_x_d;
      shelf_y_q <= shelf_y_d;
      shelf_h_q <= shelf_h_d;
      used_q    <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      status_q <= status_d;
      sout_q   <= sout_d;
      ox_q     <= ox_d;
      oy_q     <= oy_d;
      osize_q  <= osize_d;
    end
  end

  assign rsp_status_o = status_q;
  assign rsp_data_o   = {2'b00, used_q, osize_q, oy_q, ox_q, sout_q};

endmodule

@@ hw/rtl/stsa_controller.sv @@
// Controller of the allocator: request sequencing and result handshake.
// Depends on stsa_pkg; commands stsa_datapath through ctrl_cmd_t.
`timescale 1ns / 1ps
module stsa_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output stsa_pkg::ctrl_cmd_t cmd_o
);
  import stsa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_CALC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CALC;
        end
      end
      S_CALC: begin
        if (!out_valid_q || rsp_ready_i) begin
          cmd_o.execute = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.execute) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_valid_q;

endmodule

@@ hw/rtl/shadow_tile_shelf_allocator.sv @@
// Top level of the shadow tile shelf allocator: controller plus datapath.
// Depends on stsa_pkg, stsa_controller and stsa_datapath.
//
//   Channel   Direction  Handshake                 Contents
//   s_axis    in         tvalid/tready             allocate or free request
//   m_axis    out        tvalid/tready             status and placement
//   cfg       in         cfg_we_i                  limits and tile sides
//
// A request is captured in S_IDLE, then classified, placed and committed into
// the result register in S_CALC. The next request is taken while a result
// waits; a stalled result holds the controller in S_CALC until the output
// register frees. Reset clears all slots and the shelf and restores the
// register defaults at once.
`timescale 1ns / 1ps
module shadow_tile_shelf_allocator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: light_id [31:0], distance [55:32], slot [59:56], zero fill
  input  logic [stsa_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser: func
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: slot_out [3:0], atlas_x [15:4], atlas_y [27:16], tile_size [40:28],
  // active_count [45:41], zero fill
  output logic [stsa_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // tuser: status
  output logic [2:0]                        m_axis_tuser,
  input  logic                              cfg_we_i,
  input  logic [stsa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [stsa_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import stsa_pkg::*;

  ctrl_cmd_t cmd;

  stsa_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .rsp_valid_o (m_axis_tvalid),
    .rsp_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  stsa_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .req_func_i   (s_axis_tuser),
    .req_data_i   (s_axis_tdata),
    .rsp_status_o (m_axis_tuser),
    .rsp_data_o   (m_axis_tdata)
  );

endmodule

@@ hw/rtl/stsa_checker.sv @@
// Port-level checker of the shadow tile shelf allocator, bound to the top level.
// Depends on stsa_pkg and shadow_tile_shelf_allocator_defines.svh.
`timescale 1ns / 1ps
`include "shadow_tile_shelf_allocator_defines.svh"
module stsa_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [stsa_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input logic [2:0]                        m_axis_tuser
);
  import stsa_pkg::*;

  `STSA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
    "result dropped while stalled")
  `STSA_ASSERT_IMP(a_status_legal, clk_i, rst_ni, m_axis_tvalid,
    m_axis_tuser <= ST_IGNORED, "illegal status code")
  `STSA_ASSERT_IMP(a_no_place, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser != ST_ALLOCATED,
    m_axis_tdata[40:4] == '0, "placement fields set without allocation")
  `STSA_ASSERT_IMP(a_alloc_count, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == ST_ALLOCATED,
    m_axis_tdata[45:41] != '0 && m_axis_tdata[45:41] <= 5'd16, "bad count after allocation")

endmodule

bind shadow_tile_shelf_allocator stsa_checker u_stsa_checker (.*);
